@@ hdl/atss_pkg.sv @@
package atss_pkg;

  // Fixed-point format of the matrix and the accumulators.
  localparam int ACC_W     = 48;
  localparam int FRAC_BITS = 32;
  localparam int MAX_SPAN  = 64;
  localparam int MAX_DIM   = 4096;
  localparam int DIM_W     = 13;
  localparam int TEX_W     = 12;
  localparam int LEN_W     = 7;
  localparam int COORD_W   = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 48;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKEW_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SKEW_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS    = 3'd7;

  // Tiling modes.
  localparam logic [1:0] TILE_CLAMP  = 2'd0;
  localparam logic [1:0] TILE_REPEAT = 2'd1;
  localparam logic [1:0] TILE_MIRROR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_A,
    ST_MAP_B,
    ST_MAP_C,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the span inputs
    logic mul_a;   // first set of start products
    logic mul_b;   // second set of start products
    logic fin;     // form the start coordinates
    logic step;    // one pixel is emitted, advance
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register empty or draining
    logic last_pix;  // one pixel left
  } sts_t;

endpackage

@@ hdl/atss_ctrl.sv @@
module atss_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 len_zero,
  input  atss_pkg::sts_t       sts,
  output logic                 in_ready,
  output atss_pkg::cmd_t       cmd
);

  atss_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= atss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      atss_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && !len_zero) begin
          cmd.load  = 1'b1;
          state_nxt = atss_pkg::ST_MAP_A;
        end
      end
      atss_pkg::ST_MAP_A: begin
        cmd.mul_a = 1'b1;
        state_nxt = atss_pkg::ST_MAP_B;
      end
      atss_pkg::ST_MAP_B: begin
        cmd.mul_b = 1'b1;
        state_nxt = atss_pkg::ST_MAP_C;
      end
      atss_pkg::ST_MAP_C: begin
        cmd.fin   = 1'b1;
        state_nxt = atss_pkg::ST_RUN;
      end
      atss_pkg::ST_RUN: begin
        if (sts.out_free) begin
          cmd.step = 1'b1;
          if (sts.last_pix) begin
            state_nxt = atss_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = atss_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hdl/atss_dp.sv @@
module atss_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_fire,
  input  logic [atss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atss_pkg::CFG_DAT_W-1:0]  cfg_data,
  input  logic [atss_pkg::COORD_W-1:0]    start_x,
  input  logic [atss_pkg::COORD_W-1:0]    row_y,
  input  logic [atss_pkg::LEN_W-1:0]      span_length,
  input  atss_pkg::cmd_t                  cmd,
  output atss_pkg::sts_t                  sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [atss_pkg::TEX_W-1:0]      texel_x,
  output logic [atss_pkg::TEX_W-1:0]      texel_y,
  output logic                            last
);

  localparam int AW = atss_pkg::ACC_W;
  localparam int FB = atss_pkg::FRAC_BITS;
  localparam int DW = atss_pkg::DIM_W;
  localparam int PW = AW + atss_pkg::COORD_W + 2;
  localparam int TEX_W_F = atss_pkg::TEX_W;

  logic [AW-1:0] scale_x_r, skew_x_r, shift_x_r, skew_y_r, scale_y_r, shift_y_r;
  logic [1:0]    tile_r;
  logic [31:0]   dims_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r <= '0; skew_x_r <= '0; shift_x_r <= '0;
      skew_y_r  <= '0; scale_y_r <= '0; shift_y_r <= '0;
      tile_r    <= atss_pkg::TILE_CLAMP;
      dims_r    <= 32'h0001_0001;
    end else if (cfg_fire) begin
      case (cfg_index)
        atss_pkg::REG_SCALE_X: scale_x_r <= cfg_data;
        atss_pkg::REG_SKEW_X:  skew_x_r  <= cfg_data;
        atss_pkg::REG_SHIFT_X: shift_x_r <= cfg_data;
        atss_pkg::REG_SKEW_Y:  skew_y_r  <= cfg_data;
        atss_pkg::REG_SCALE_Y: scale_y_r <= cfg_data;
        atss_pkg::REG_SHIFT_Y: shift_y_r <= cfg_data;
        atss_pkg::REG_TILE:    tile_r    <= cfg_data[1:0];
        atss_pkg::REG_DIMS:    dims_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero reads as one, large values saturate.
  function automatic logic [DW-1:0] dim_of(input logic [15:0] d);
    logic [DW-1:0] r;
    if (d == 16'd0) r = DW'(1);
    else if (d > 16'(atss_pkg::MAX_DIM)) r = DW'(atss_pkg::MAX_DIM);
    else r = d[DW-1:0];
    return r;
  endfunction

  logic [DW-1:0] dim_w, dim_h;
  assign dim_w = dim_of(dims_r[15:0]);
  assign dim_h = dim_of(dims_r[31:16]);

  // Span inputs, odd pixel-centre multipliers and the remaining count.
  logic [atss_pkg::COORD_W:0] ox_r, oy_r;
  logic [atss_pkg::LEN_W-1:0] left_r;
  logic [PW-1:0]              pa_r, pb_r;
  logic [AW-1:0]              u_r, v_r;

  // The 48 by 15 bit start products are formed two at a time, one with ox_r and one with oy_r.
  logic [PW-1:0] prod;
  logic [AW-1:0] mul_a, mul_b;
  logic [atss_pkg::COORD_W:0] mul_o;
  always_comb begin
    mul_a = cmd.mul_a ? scale_x_r : skew_y_r;
    mul_b = cmd.mul_a ? skew_x_r  : scale_y_r;
    mul_o = ox_r;
    prod  = '0;
    if (cmd.mul_a || cmd.mul_b) begin
      prod = PW'($signed(mul_a) * $signed({1'b0, mul_o}));
    end
  end

  logic [PW-1:0] mb_r;
  logic [PW-1:0] prod_b;
  assign prod_b = PW'($signed(mul_b) * $signed({1'b0, oy_r}));

  logic [AW:0] sum_u, sum_v;
  assign sum_u = pa_r[AW:0] + mb_r[AW:0];

  logic [PW-1:0] pc_r, pd_r;
  assign sum_v = pc_r[AW:0] + pd_r[AW:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ox_r <= {start_x, 1'b1};
      oy_r <= {row_y, 1'b1};
      left_r <= (span_length > 7'(atss_pkg::MAX_SPAN)) ?
                7'(atss_pkg::MAX_SPAN) : span_length;
    end
    if (cmd.mul_a) begin
      pa_r <= prod;
      mb_r <= prod_b;
    end
    if (cmd.mul_b) begin
      pc_r <= prod;
      pd_r <= prod_b;
    end
    if (cmd.fin) begin
      u_r <= sum_u[AW:1] + shift_x_r;
      v_r <= sum_v[AW:1] + shift_y_r;
    end
    if (cmd.step) begin
      u_r    <= u_r + scale_x_r;
      v_r    <= v_r + skew_y_r;
      left_r <= left_r - 7'd1;
    end
  end

  // Tiling then scaling by the bitmap dimension.
  function automatic logic [TEX_W_F-1:0] tile_scale(
    input logic [AW-1:0] a, input logic [1:0] mode, input logic [DW-1:0] dim);
    logic [FB:0]       t;
    logic [FB:0]       m;
    logic [FB+DW:0]    p;
    logic [DW:0]       tx;
    t = '0;
    m = a[FB:0];
    if (mode == atss_pkg::TILE_REPEAT) begin
      t = {1'b0, a[FB-1:0]};
    end else if (mode == atss_pkg::TILE_MIRROR) begin
      t = (m > {1'b1, {FB{1'b0}}}) ? ({1'b1, {FB{1'b0}}} - {1'b0, m[FB-1:0]}) : m;
    end else begin
      if (a[AW-1]) t = '0;
      else if (a[AW-2:FB] != '0) t = {1'b0, {FB{1'b1}}};
      else t = {1'b0, a[FB-1:0]};
    end
    p  = t * dim;
    tx = p[FB+DW:FB];
    if (tx > {1'b0, dim} - (DW+1)'(1)) tx = {1'b0, dim} - (DW+1)'(1);
    return tx[TEX_W_F-1:0];
  endfunction

  // Output register.
  logic                           ov_r;
  logic [atss_pkg::TEX_W-1:0]     tx_r, ty_r;
  logic                           last_r;
  assign sts.out_free = !ov_r || out_ready;
  assign sts.last_pix = (left_r == 7'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.step) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      tx_r   <= tile_scale(u_r, tile_r, dim_w);
      ty_r   <= tile_scale(v_r, tile_r, dim_h);
      last_r <= (left_r == 7'd1);
    end
  end

  assign out_valid = ov_r;
  assign texel_x   = tx_r;
  assign texel_y   = ty_r;
  assign last      = last_r;

endmodule

@@ hdl/affine_texture_span_sampler.sv @@
// An accepted span is loaded, passes the states MAP_A, MAP_B and MAP_C, then emits its pixels in RUN.
// Throughput: one pixel per cycle while the output is not stalled; a new span is taken only when idle.
// The start mapping runs through one shared 48 by 15 bit multiplier pair.
// Reset (rst_n, synchronous, active low) clears the controller, the output
// valid and all configuration registers; dimensions reset to one by one.
module affine_texture_span_sampler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // start_x[13:0], row_y[27:14], span_length[34:28]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // texel_x[11:0], texel_y[23:12]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  atss_pkg::cmd_t cmd;
  atss_pkg::sts_t sts;
  logic           in_fire;
  logic [11:0]    tx, ty;

  assign cfg_ready = 1'b1;
  assign in_fire   = s_axis_tvalid && s_axis_tready;

  atss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .len_zero (s_axis_tdata[34:28] == 7'd0),
    .sts      (sts),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  atss_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_fire    (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .start_x     (s_axis_tdata[13:0]),
    .row_y       (s_axis_tdata[27:14]),
    .span_length (s_axis_tdata[34:28]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .texel_x     (tx),
    .texel_y     (ty),
    .last        (m_axis_tlast)
  );

  assign m_axis_tdata = {ty, tx};

endmodule

@@ hdl/atss_checker.sv @@
module atss_checker (
  input logic clk,
  input logic rst_n,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast
);

  // The block never takes a span while pixels are still produced.
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("span accepted mid-span");

  // A stalled result stays valid.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // No result appears in the cycle after reset.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind affine_texture_span_sampler atss_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast)
);
